@@ hw/rtl/gpt_pkg.sv @@
// gpt_pkg: shared types, codes and constants for the gateway preference table
// used by gpt_alu, gpt_table, gpt_ctrl and gateway_preference_table
// no dependencies
`timescale 1ns / 1ps

package gpt_pkg;

   // table sizing
   localparam int DEFAULT_TABLE_DEPTH = 16;

   // fixed field widths
   localparam int ADDR_W      = 32;
   localparam int PREF_W      = 32;
   localparam int TIME_W      = 32;
   localparam int AGE_CFG_W   = 20;
   localparam int OFFSET_W    = 17;
   localparam int COUNT_W     = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 72;

   // preference constants
   localparam logic [PREF_W-1:0] EXPIRED_PREF       = 32'h8000_0000;
   localparam logic [PREF_W-1:0] RIP_BASE_PREF      = 32'd512;
   localparam logic [PREF_W-1:0] RIP_UNREACH_PREF   = 32'd1;

   // register reset values
   localparam logic [AGE_CFG_W-1:0] VALID_LIFETIME_RST  = 20'd600;
   localparam logic [AGE_CFG_W-1:0] REPLACE_AGE_RST     = 20'd300;
   localparam logic [AGE_CFG_W-1:0] PURGE_AGE_RST       = 20'd86400;
   localparam logic [OFFSET_W-1:0]  PREF_OFFSET_RST     = 17'h1FC00;

   // request op codes
   localparam logic [1:0] OP_ADD_PREF  = 2'd0;
   localparam logic [1:0] OP_ADD_RIP   = 2'd1;
   localparam logic [1:0] OP_ADVERTISE = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_ADD_OUTCOME = 2'd0;
   localparam logic [1:0] KIND_ADV_ENTRY   = 2'd1;
   localparam logic [1:0] KIND_ADV_END     = 2'd2;

   // add status codes
   localparam logic [2:0] ST_MATCH_UPDATED = 3'd0;
   localparam logic [2:0] ST_MATCH_KEPT    = 3'd1;
   localparam logic [2:0] ST_NEW_SLOT      = 3'd2;
   localparam logic [2:0] ST_REPLACED      = 3'd3;
   localparam logic [2:0] ST_DROPPED       = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VALID_LIFETIME  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACE_AGE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PURGE_AGE       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREF_OFFSET     = 3'd3;

   // one table entry
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [PREF_W-1:0] pref;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   // configuration registers
   typedef struct packed {
      logic [AGE_CFG_W-1:0] valid_lifetime;
      logic [AGE_CFG_W-1:0] replace_age;
      logic [AGE_CFG_W-1:0] purge_age;
      logic [OFFSET_W-1:0]  pref_offset;
   } cfg_type;

   // shared adder operands and results
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        sub;
   } alu_req_type;

   typedef struct packed {
      logic [31:0] sum;
      logic        lt_signed;
   } alu_rsp_type;

endpackage

@@ hw/rtl/gpt_alu.sv @@
// gpt_alu: shared 32-bit add/subtract unit with signed less-than flag
// depends on gpt_pkg
`timescale 1ns / 1ps

module gpt_alu (
   input  gpt_pkg::alu_req_type alu_req,
   output gpt_pkg::alu_rsp_type alu_rsp
);
   import gpt_pkg::*;

   logic [32:0] ext_sum;
   logic [31:0] b_opnd;

   // a + b, or a + ~b + 1 for subtract
   assign b_opnd  = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign ext_sum = {1'b0, alu_req.a} + {1'b0, b_opnd} + {32'd0, alu_req.sub};

   // signed a < b: sign bits decide when they differ, else no carry means a < b
   assign alu_rsp.sum       = ext_sum[31:0];
   assign alu_rsp.lt_signed = (alu_req.a[31] != alu_req.b[31]) ? alu_req.a[31]
                                                                : ~ext_sum[32];

endmodule

@@ hw/rtl/gpt_table.sv @@
// gpt_table: entry memory, one write port and one registered read port
// depends on gpt_pkg
`timescale 1ns / 1ps

module gpt_table #(
   parameter int TABLE_DEPTH = gpt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  gpt_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_idx,
   output gpt_pkg::entry_type  rd_data
);
   import gpt_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/gpt_ctrl.sv @@
// gpt_ctrl: sequencer for add and advertise, scan bookkeeping, result register
// depends on gpt_pkg, gpt_alu
`timescale 1ns / 1ps

module gpt_ctrl #(
   parameter int TABLE_DEPTH = gpt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gpt_pkg::cfg_type                   cfg,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gpt_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                         req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gpt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   // table ports
   output logic                               mem_wr_en,
   output logic [IDX_W-1:0]                   mem_wr_idx,
   output gpt_pkg::entry_type                 mem_wr_data,
   output logic                               mem_rd_en,
   output logic [IDX_W-1:0]                   mem_rd_idx,
   input  gpt_pkg::entry_type                 mem_rd_data
);
   import gpt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RIP_BASE,
      S_RIP_OFFSET,
      S_SCAN,
      S_DECIDE,
      S_UPDATE,
      S_ADD_RESULT,
      S_ADV_END
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [ADDR_W-1:0]  host_ff, host_in;
   logic [PREF_W-1:0]  new_pref_ff, new_pref_in;
   logic [31:0]        metric_ff, metric_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               dv_ff, dv_in;
   logic [IDX_W-1:0]   dv_idx_ff, dv_idx_in;
   logic               found_ff, found_in;
   logic               have_old_ff, have_old_in;
   logic [IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic [TIME_W-1:0]  old_age_ff, old_age_in;
   logic [TIME_W-1:0]  old_stamp_ff, old_stamp_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [PREF_W-1:0]  cur_pref_ff, cur_pref_in;
   logic [TIME_W-1:0]  cur_age_ff, cur_age_in;
   logic [TIME_W-1:0]  cur_stamp_ff, cur_stamp_in;
   logic               dirty_ff, dirty_in;
   logic [2:0]         status_ff, status_in;
   logic [COUNT_W-1:0] live_ff, live_in;
   // result register
   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_kind_ff, out_kind_in;
   logic [2:0]         out_status_ff, out_status_in;
   logic [ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [PREF_W-1:0]  out_pref_ff, out_pref_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic               out_last_ff, out_last_in;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic              out_free;
   logic              issue_done;
   logic [TIME_W-1:0] age;
   logic              hit;
   logic              stale_age;
   logic              update;

   gpt_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // shared adder operand select
   always_comb begin
      alu_req = '{a: now_ff, b: mem_rd_data.stamp, sub: 1'b1};
      case (state_ff)
         S_RIP_BASE:   alu_req = '{a: RIP_BASE_PREF, b: metric_ff, sub: 1'b1};
         S_RIP_OFFSET: alu_req = '{a: new_pref_ff,
                                   b: {{(32-OFFSET_W){cfg.pref_offset[OFFSET_W-1]}},
                                       cfg.pref_offset},
                                   sub: 1'b0};
         S_UPDATE:     alu_req = '{a: new_pref_ff, b: cur_pref_ff, sub: 1'b1};
         default:      alu_req = '{a: now_ff, b: mem_rd_data.stamp, sub: 1'b1};
      endcase
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign issue_done = (issue_ff == count_ff);
   assign age        = alu_rsp.sum;
   assign hit        = dv_ff && (mem_rd_data.addr == host_ff);
   assign stale_age  = age > {12'd0, cfg.valid_lifetime};
   assign update     = !alu_rsp.lt_signed || (cur_age_ff >= {12'd0, cfg.replace_age});

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      host_in       = host_ff;
      new_pref_in   = new_pref_ff;
      metric_in     = metric_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      dv_in         = 1'b0;
      dv_idx_in     = dv_idx_ff;
      found_in      = found_ff;
      have_old_in   = have_old_ff;
      old_idx_in    = old_idx_ff;
      old_age_in    = old_age_ff;
      old_stamp_in  = old_stamp_ff;
      slot_in       = slot_ff;
      cur_pref_in   = cur_pref_ff;
      cur_age_in    = cur_age_ff;
      cur_stamp_in  = cur_stamp_ff;
      dirty_in      = dirty_ff;
      status_in     = status_ff;
      live_in       = live_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_status_in = out_status_ff;
      out_addr_in   = out_addr_ff;
      out_pref_in   = out_pref_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      mem_rd_en     = 1'b0;
      mem_rd_idx    = issue_ff[IDX_W-1:0];
      mem_wr_en     = 1'b0;
      mem_wr_idx    = slot_ff;
      mem_wr_data   = '{addr: host_ff, pref: new_pref_ff, stamp: now_ff};
      req_tready    = (state_ff == S_IDLE);

      case (state_ff)
         // take a request and clear the scan bookkeeping
         S_IDLE: begin
            if (req_tvalid) begin
               op_in       = req_tuser;
               host_in     = req_tdata[31:0];
               new_pref_in = req_tdata[63:32];
               metric_in   = req_tdata[95:64];
               now_in      = req_tdata[127:96];
               issue_in    = '0;
               found_in    = 1'b0;
               have_old_in = 1'b0;
               live_in     = '0;
               case (req_tuser)
                  OP_ADD_PREF:  state_in = S_SCAN;
                  OP_ADD_RIP:   state_in = S_RIP_BASE;
                  OP_ADVERTISE: state_in = S_SCAN;
                  default:      state_in = S_IDLE;
               endcase
            end
         end

         // rip preference: base minus metric, unreachable metrics give one
         S_RIP_BASE: begin
            new_pref_in = (|metric_ff[31:8]) ? RIP_UNREACH_PREF : alu_rsp.sum;
            state_in    = S_RIP_OFFSET;
         end

         S_RIP_OFFSET: begin
            new_pref_in = alu_rsp.sum;
            state_in    = S_SCAN;
         end

         // one entry read per cycle unless stalled, evaluated the cycle after
         S_SCAN: begin
            if (op_ff == OP_ADVERTISE) begin
               if (dv_ff && (age <= {12'd0, cfg.purge_age})) begin
                  if (out_free) begin
                     out_valid_in  = 1'b1;
                     out_kind_in   = KIND_ADV_ENTRY;
                     out_status_in = ST_MATCH_UPDATED;
                     out_addr_in   = mem_rd_data.addr;
                     out_pref_in   = stale_age ? EXPIRED_PREF : mem_rd_data.pref;
                     out_count_in  = '0;
                     out_last_in   = 1'b0;
                     live_in       = live_ff + COUNT_W'(1);
                     // expired entries are marked dead in place
                     mem_wr_en     = stale_age;
                     mem_wr_idx    = dv_idx_ff;
                     mem_wr_data   = '{addr: mem_rd_data.addr, pref: EXPIRED_PREF,
                                       stamp: mem_rd_data.stamp};
                     mem_rd_en     = !issue_done;
                  end else begin
                     // receiver stalled: hold the entry under evaluation
                     dv_in = 1'b1;
                  end
               end else begin
                  mem_rd_en = !issue_done;
               end
               if (issue_done && !dv_ff) begin
                  state_in = S_ADV_END;
               end
            end else begin
               if (hit) begin
                  found_in     = 1'b1;
                  slot_in      = dv_idx_ff;
                  cur_pref_in  = mem_rd_data.pref;
                  cur_age_in   = age;
                  cur_stamp_in = mem_rd_data.stamp;
                  state_in     = S_DECIDE;
               end else begin
                  if (dv_ff && (!have_old_ff || age > old_age_ff)) begin
                     have_old_in  = 1'b1;
                     old_idx_in   = dv_idx_ff;
                     old_age_in   = age;
                     old_stamp_in = mem_rd_data.stamp;
                  end
                  mem_rd_en = !issue_done;
                  if (issue_done && !dv_ff) begin
                     state_in = S_DECIDE;
                  end
               end
            end
            if (mem_rd_en) begin
               dv_in     = 1'b1;
               dv_idx_in = issue_ff[IDX_W-1:0];
               issue_in  = issue_ff + CNT_W'(1);
            end
         end

         // pick matching entry, stale oldest entry, a fresh slot or drop
         S_DECIDE: begin
            dirty_in = 1'b0;
            state_in = S_UPDATE;
            if (found_ff) begin
               status_in = ST_MATCH_KEPT;
            end else if (have_old_ff && (old_age_ff > {12'd0, cfg.valid_lifetime})) begin
               status_in    = ST_REPLACED;
               slot_in      = old_idx_ff;
               cur_pref_in  = EXPIRED_PREF;
               cur_age_in   = old_age_ff;
               cur_stamp_in = old_stamp_ff;
               dirty_in     = 1'b1;
            end else if (count_ff < CNT_W'(TABLE_DEPTH)) begin
               status_in    = ST_NEW_SLOT;
               slot_in      = count_ff[IDX_W-1:0];
               count_in     = count_ff + CNT_W'(1);
               cur_pref_in  = EXPIRED_PREF;
               cur_age_in   = '0;
               cur_stamp_in = now_ff;
               dirty_in     = 1'b1;
            end else begin
               status_in = ST_DROPPED;
               state_in  = S_ADD_RESULT;
            end
         end

         // write the new preference if no worse or the entry is old enough
         S_UPDATE: begin
            mem_wr_en = update || dirty_ff;
            if (update) begin
               mem_wr_data = '{addr: host_ff, pref: new_pref_ff, stamp: now_ff};
               if (status_ff == ST_MATCH_KEPT) begin
                  status_in = ST_MATCH_UPDATED;
               end
            end else begin
               mem_wr_data = '{addr: host_ff, pref: EXPIRED_PREF, stamp: cur_stamp_ff};
            end
            state_in = S_ADD_RESULT;
         end

         S_ADD_RESULT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_ADD_OUTCOME;
               out_status_in = status_ff;
               out_addr_in   = '0;
               out_pref_in   = '0;
               out_count_in  = '0;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_ADV_END: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_ADV_END;
               out_status_in = ST_MATCH_UPDATED;
               out_addr_in   = '0;
               out_pref_in   = '0;
               out_count_in  = live_ff;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff         <= op_in;
      host_ff       <= host_in;
      new_pref_ff   <= new_pref_in;
      metric_ff     <= metric_in;
      now_ff        <= now_in;
      issue_ff      <= issue_in;
      dv_idx_ff     <= dv_idx_in;
      found_ff      <= found_in;
      have_old_ff   <= have_old_in;
      old_idx_ff    <= old_idx_in;
      old_age_ff    <= old_age_in;
      old_stamp_ff  <= old_stamp_in;
      slot_ff       <= slot_in;
      cur_pref_ff   <= cur_pref_in;
      cur_age_ff    <= cur_age_in;
      cur_stamp_ff  <= cur_stamp_in;
      dirty_ff      <= dirty_in;
      status_ff     <= status_in;
      live_ff       <= live_in;
      out_kind_ff   <= out_kind_in;
      out_status_ff <= out_status_in;
      out_addr_ff   <= out_addr_in;
      out_pref_ff   <= out_pref_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   // result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_count_ff, out_pref_ff, out_addr_ff, out_status_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ hw/rtl/gateway_preference_table.sv @@
// gateway_preference_table: top level with configuration registers
// depends on gpt_pkg, gpt_table, gpt_ctrl (which uses gpt_alu)
`timescale 1ns / 1ps

// Keeps up to TABLE_DEPTH router entries (address, signed preference, time stamp).
// Request channel (req_): tuser carries the op, tdata the address, preference,
// metric and current time. Op 0 adds with a given preference, op 1 adds with a
// preference derived from a rip metric, op 2 advertises the table. Op 3 is
// accepted and dropped. Result channel (rsp_): an add returns one outcome with
// tlast set; an advertise returns one result per live entry and then an end
// result holding the count, with tlast set.
// Each request scans the stored entries through a single read port, one entry
// per cycle unless a stalled receiver holds an advertise. An add with no match
// scans every entry, decides, updates and presents its outcome, then is ready
// again; a match ends the scan early, a full table with nothing stale skips
// the update and op 1 first derives the rip preference. An advertise scans
// every stored entry and then presents its end result. The block takes one
// request at a time; req_tready is high only between requests. A finished
// result waits in an output register: a stalled receiver holds an advertise
// scan and the final result of either op, but the next request may be taken
// while a result is still pending.
// Reset empties the table and loads the register defaults; no clearing pass.
// Configuration writes (csr_) are always accepted and should be made idle.

module gateway_preference_table #(
   parameter int TABLE_DEPTH = gpt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: tdata = gateway_addr, given_pref, rip_metric, now_seconds
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [gpt_pkg::REQ_DATA_W-1:0]        req_tdata,
   // request: tuser = op
   input  logic [1:0]                            req_tuser,
   // result: tdata = add_status, entry_addr, entry_pref, live_count
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gpt_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // result: tuser = result_kind
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gpt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [gpt_pkg::CSR_DATA_W-1:0]        csr_data
);
   import gpt_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   cfg_type          cfg_ff, cfg_in;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_idx;
   entry_type        mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_idx;
   entry_type        mem_rd_data;

   // register write decode
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VALID_LIFETIME:  cfg_in.valid_lifetime  = csr_data;
            CSR_REPLACE_AGE:     cfg_in.replace_age     = csr_data;
            CSR_PURGE_AGE:       cfg_in.purge_age       = csr_data;
            CSR_PREF_OFFSET:     cfg_in.pref_offset     = csr_data[OFFSET_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{valid_lifetime:  VALID_LIFETIME_RST,
                     replace_age:     REPLACE_AGE_RST,
                     purge_age:       PURGE_AGE_RST,
                     pref_offset:     PREF_OFFSET_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // entry memory
   gpt_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_idx  (mem_wr_idx),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_idx  (mem_rd_idx),
      .rd_data (mem_rd_data)
   );

   // sequencer
   gpt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_idx  (mem_wr_idx),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_idx  (mem_rd_idx),
      .mem_rd_data (mem_rd_data)
   );

endmodule

@@ tb/tb_gateway_preference_table.sv @@
// tb_gateway_preference_table: self-checking testbench for the gateway preference table
// drives requests and register writes, predicts every result, compares them in order
// depends on gpt_pkg and gateway_preference_table
`timescale 1ns / 1ps

module tb_gateway_preference_table;
   import gpt_pkg::*;

   localparam int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int POOL_SIZE    = 20;

   // codes the package leaves out
   localparam logic [1:0]             OP_UNUSED        = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd5;
   localparam logic [31:0]            RIP_UNREACHABLE  = 32'd256;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] addr;
      logic [31:0] pref;
      logic [31:0] metric;
      logic [31:0] now;
   } gw_request_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  status;
      logic [31:0] addr;
      logic [31:0] pref;
      logic [4:0]  count;
      logic        last;
   } gw_result_type;

   // dut ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [1:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // mirror of the gateway table and its registers
   logic [19:0]        cfg_lifetime = VALID_LIFETIME_RST;
   logic [19:0]        cfg_replace  = REPLACE_AGE_RST;
   logic [19:0]        cfg_purge    = PURGE_AGE_RST;
   logic signed [16:0] cfg_offset   = PREF_OFFSET_RST;
   int                 gw_count = 0;
   logic [31:0]        gw_addr  [TABLE_DEPTH];
   logic [31:0]        gw_pref  [TABLE_DEPTH];
   logic [31:0]        gw_stamp [TABLE_DEPTH];
   gw_result_type      pending_outcomes[$];

   // stimulus state
   logic [31:0] addr_pool [POOL_SIZE];
   logic [31:0] now_base = '0;
   logic        req_offered = 1'b0;
   logic        hold_active = 1'b0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   event        hold_rsp;

   // run statistics
   int unsigned error_count = 0;
   int unsigned results_checked = 0;
   int unsigned n_adds = 0;
   int unsigned n_adverts = 0;
   int unsigned n_ignored = 0;
   int unsigned status_seen [5] = '{default: 0};
   int unsigned cycle_count = 0;

   gateway_preference_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // gateway_addr, given_pref, rip_metric, now_seconds
      .req_tuser  (req_tuser),   // op
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // add_status, entry_addr, entry_pref, live_count
      .rsp_tuser  (rsp_tuser),   // result_kind
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // long receiver hold-off, counted here
   initial begin : rsp_hold_timer
      forever begin
         @(hold_rsp);
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // receiver readiness
   always @(posedge clock) begin
      rsp_tready <= !hold_active && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // compare each accepted result with the oldest outcome still owed
   always @(posedge clock) begin : compare_results
      gw_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (pending_outcomes.size() == 0) begin
            $error("result_kind %0d arrived with nothing outstanding", rsp_tuser);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("result_kind", want.kind, rsp_tuser);
            check_field("add_status", want.status, rsp_tdata[2:0]);
            check_field("entry_addr", want.addr, rsp_tdata[34:3]);
            check_field("entry_pref", want.pref, rsp_tdata[66:35]);
            check_field("live_count", want.count, rsp_tdata[71:67]);
            check_field("last", want.last, rsp_tlast);
         end
      end
   end

   // add with a signed preference, returns the add status
   function automatic logic [2:0] mirror_add(input logic [31:0] host,
                                             input logic signed [31:0] pref,
                                             input logic [31:0] now);
      int          slot;
      int          oldest;
      logic [31:0] oldest_age;
      logic [31:0] age;
      bit          found;
      bit          have_oldest;
      logic [2:0]  status;
      slot = 0;
      oldest = 0;
      oldest_age = '0;
      found = 1'b0;
      have_oldest = 1'b0;
      // look for the address, track the oldest entry on the way
      for (int i = 0; i < gw_count && !found; i++) begin
         age = now - gw_stamp[i];
         if (gw_addr[i] == host) begin
            found = 1'b1;
            slot = i;
         end else if (!have_oldest || age > oldest_age) begin
            have_oldest = 1'b1;
            oldest = i;
            oldest_age = age;
         end
      end
      if (found) begin
         status = ST_MATCH_KEPT;
      end else if (have_oldest && oldest_age > cfg_lifetime) begin
         slot = oldest;
         status = ST_REPLACED;
         gw_addr[slot] = host;
         gw_pref[slot] = EXPIRED_PREF;
      end else if (gw_count < TABLE_DEPTH) begin
         slot = gw_count;
         gw_count++;
         status = ST_NEW_SLOT;
         gw_addr[slot] = host;
         gw_pref[slot] = EXPIRED_PREF;
         gw_stamp[slot] = now;
      end else begin
         return ST_DROPPED;
      end
      // write if at least as good or old enough
      age = now - gw_stamp[slot];
      if (pref >= $signed(gw_pref[slot]) || age >= cfg_replace) begin
         gw_pref[slot] = pref;
         gw_stamp[slot] = now;
         if (status == ST_MATCH_KEPT) status = ST_MATCH_UPDATED;
      end
      return status;
   endfunction

   // update the mirror for one accepted request and queue its results
   function automatic void apply_request(input gw_request_type rq);
      logic signed [31:0] rip_pref;
      logic [31:0]        age;
      logic [2:0]         status;
      int unsigned        live;
      live = 0;
      case (rq.op)
         OP_ADD_PREF, OP_ADD_RIP: begin
            if (rq.op == OP_ADD_PREF) begin
               rip_pref = rq.pref;
            end else begin
               if (rq.metric >= RIP_UNREACHABLE) rip_pref = $signed(RIP_UNREACH_PREF);
               else rip_pref = $signed(RIP_BASE_PREF) - $signed(rq.metric);
               rip_pref = rip_pref + cfg_offset;
            end
            status = mirror_add(rq.addr, rip_pref, rq.now);
            status_seen[status]++;
            n_adds++;
            pending_outcomes.push_back(gw_result_type'{KIND_ADD_OUTCOME, status, 32'd0,
                                                       32'd0, 5'd0, 1'b1});
         end
         OP_ADVERTISE: begin
            n_adverts++;
            for (int i = 0; i < gw_count; i++) begin
               age = rq.now - gw_stamp[i];
               if (age <= cfg_purge) begin
                  live++;
                  if (age > cfg_lifetime) gw_pref[i] = EXPIRED_PREF;
                  pending_outcomes.push_back(gw_result_type'{KIND_ADV_ENTRY,
                                                             ST_MATCH_UPDATED, gw_addr[i],
                                                             gw_pref[i], 5'd0, 1'b0});
               end
            end
            pending_outcomes.push_back(gw_result_type'{KIND_ADV_END, ST_MATCH_UPDATED,
                                                       32'd0, 32'd0, 5'(live), 1'b1});
         end
         default: n_ignored++;
      endcase
   endfunction

   task automatic stop_offering();
      if (req_offered) begin
         req_tvalid <= 1'b0;
         req_offered = 1'b0;
      end
   endtask

   // offer one request and wait for it to be taken; valid stays up afterwards
   task automatic send_request(input gw_request_type rq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         stop_offering();
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_offered = 1'b1;
      req_tuser  <= rq.op;
      req_tdata  <= {rq.now, rq.metric, rq.pref, rq.addr};
      do @(posedge clock); while (!req_tready);
      apply_request(rq);
   endtask

   task automatic wait_outcomes_empty();
      stop_offering();
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // drained, then let an ignored request finish inside the block
   task automatic wait_drained();
      wait_outcomes_empty();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all registers plus one unused index while idle
   task automatic configure(input logic [19:0] lifetime, replace, purge,
                            input logic [16:0] offset);
      logic [CSR_INDEX_W-1:0] idx [5];
      logic [19:0]            val [5];
      wait_drained();
      idx = '{CSR_VALID_LIFETIME, CSR_REPLACE_AGE, CSR_PURGE_AGE, CSR_PREF_OFFSET,
              CSR_UNUSED_INDEX};
      val = '{lifetime, replace, purge, {3'($urandom), offset}, 20'($urandom)};
      for (int k = 0; k < 5; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         do @(posedge clock); while (!csr_ready);
         case (idx[k])
            CSR_VALID_LIFETIME:  cfg_lifetime = val[k];
            CSR_REPLACE_AGE:     cfg_replace = val[k];
            CSR_PURGE_AGE:       cfg_purge = val[k];
            CSR_PREF_OFFSET:     cfg_offset = val[k][16:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // addresses mostly from a small pool so matches, full table and eviction happen
   function automatic gw_request_type random_request();
      gw_request_type rq;
      int             pick;
      pick = $urandom_range(0, 99);
      rq.op = pick < 40 ? OP_ADD_PREF : pick < 72 ? OP_ADD_RIP :
              pick < 93 ? OP_ADVERTISE : OP_UNUSED;
      rq.addr = ($urandom_range(0, 9) == 0) ? $urandom
                                             : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 9);
      rq.pref = pick < 5 ? 32'($urandom_range(0, 2000)) - 32'd1000 :
                pick < 8 ? 32'($urandom) : pick == 8 ? EXPIRED_PREF : 32'h7FFF_FFFF;
      pick = $urandom_range(0, 9);
      rq.metric = pick < 7 ? 32'($urandom_range(0, 300)) :
                  pick < 9 ? 32'($urandom) : 32'd255 + 32'($urandom_range(0, 1));
      // time mostly creeps, sometimes jumps, now and then lands anywhere
      pick = $urandom_range(0, 99);
      if (pick < 70) now_base += $urandom_range(0, 40);
      else if (pick < 96) now_base += $urandom_range(0, 1200);
      else now_base = $urandom;
      rq.now = now_base;
      return rq;
   endfunction

   task automatic run_random(input int count);
      gw_request_type rq;
      int             sent;
      sent = 0;
      while (sent < count) begin
         rq = random_request();
         send_request(rq);
         if (rq.op != OP_UNUSED) sent++;
      end
   endtask

   // default registers: status outcomes, rip metrics, expiry, purge and time wrap
   task automatic test_reset_defaults();
      send_request('{OP_ADD_PREF, 32'h0000_0000, 32'd100, 32'd0, 32'd1000});
      send_request('{OP_ADD_PREF, 32'h0000_0000, 32'd50, 32'd0, 32'd1010});
      send_request('{OP_ADD_PREF, 32'h0000_0000, 32'd100, 32'd0, 32'd1020});
      send_request('{OP_ADD_PREF, 32'h0000_0000, EXPIRED_PREF, 32'd0, 32'd1400});
      send_request('{OP_ADD_PREF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd1400});
      send_request('{OP_ADD_RIP, 32'hFFFF_FFFF, 32'h0, 32'd0, 32'd1410});
      send_request('{OP_ADD_RIP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1420});
      send_request('{OP_ADD_RIP, 32'h8000_0001, 32'd0, 32'd256, 32'd1430});
      send_request('{OP_ADD_RIP, 32'h8000_0001, 32'd0, 32'd255, 32'd1440});
      send_request('{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_request('{OP_ADVERTISE, 32'd0, 32'd0, 32'd0, 32'd1500});
      send_request('{OP_ADVERTISE, 32'd0, 32'd0, 32'd0, 32'd2010});
      // every entry past the purge age
      send_request('{OP_ADVERTISE, 32'd0, 32'd0, 32'd0, 32'd1440 + 32'd86401});
      // evict the oldest, two entries tie on age
      send_request('{OP_ADD_PREF, 32'h1234_5678, 32'd5, 32'd0, 32'hFFFF_FFF0});
      send_request('{OP_ADVERTISE, 32'd0, 32'd0, 32'd0, 32'h0000_0010});
      now_base = 32'h0000_0010;
   endtask

   // fill the table, drop when full, then evict once entries go stale
   task automatic test_full_then_stale();
      now_base += 5;
      while (gw_count < TABLE_DEPTH)
         send_request('{OP_ADD_PREF, 32'($urandom), 32'($urandom_range(0, 500)), 32'd0,
                        now_base});
      send_request('{OP_ADD_PREF, 32'($urandom), 32'h7FFF_FFFF, 32'd0, now_base});
      send_request('{OP_ADD_RIP, 32'($urandom), 32'd0, 32'($urandom_range(0, 255)),
                     now_base + 32'd1});
      now_base += cfg_lifetime + 32'd2;
      // a present address wins over stale entries
      send_request('{OP_ADD_PREF, gw_addr[TABLE_DEPTH - 1], 32'($urandom), 32'd0, now_base});
      send_request('{OP_ADD_PREF, 32'($urandom), 32'($urandom), 32'd0, now_base});
      send_request('{OP_ADD_RIP, 32'($urandom), 32'd0, 32'($urandom), now_base});
      send_request('{OP_ADVERTISE, 32'd0, 32'd0, 32'd0, now_base});
   endtask

   // all ages zero, then all ages at their largest
   task automatic test_register_extremes();
      configure(20'd0, 20'd0, 20'd0, 17'h00000);
      run_random(25);
      configure(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 17'h0FFFF);
      run_random(25);
   endtask

   // most negative offset, then back to the reset values
   task automatic test_offset_extremes();
      configure(20'($urandom_range(100, 900)), 20'($urandom_range(50, 400)),
                20'($urandom_range(1000, 5000)), 17'h10000);
      run_random(25);
      configure(VALID_LIFETIME_RST, REPLACE_AGE_RST, PURGE_AGE_RST, PREF_OFFSET_RST);
      run_random(25);
   endtask

   // receiver stalls long enough for the block to back up its input
   task automatic test_receiver_hold();
      -> hold_rsp;
      run_random(12);
      wait_outcomes_empty();
   endtask

   // bursts with a full drain between them
   task automatic test_drain_pause();
      repeat (3) begin
         run_random(15);
         wait_outcomes_empty();
      end
   endtask

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
      send_idle_pct = 25;
      recv_idle_pct = 71;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_full_then_stale();
      test_register_extremes();
      send_idle_pct = 71;
      recv_idle_pct = 25;
      test_offset_extremes();
      test_receiver_hold();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_drain_pause();
      wait_drained();
      $display("covered %0d adds, %0d advertisements, %0d ignored ops, %0d results checked",
               n_adds, n_adverts, n_ignored, results_checked);
      $display("add outcomes: %0d updated, %0d kept, %0d new, %0d evicted, %0d dropped",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
